@@ rtl/core/sspr_pkg.sv @@
package sspr_pkg;

  // Payload store geometry. The byte_index port is fixed at 6 bits, so the
  // store depth stays at 64 entries.
  localparam int unsigned AddrW   = 6;
  localparam int unsigned MaxData = 64;

  // Bytes that may pass without completing a header before the hunt gives up.
  localparam logic [4:0] HuntLimit = 5'd20;

  localparam logic [7:0] HeaderByte = 8'hFF;
  localparam logic [7:0] MinLength  = 8'd2;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StNoHdr   = 3'd1,
    StShort   = 3'd2,
    StCsum    = 3'd3,
    StLong    = 3'd4,
    StTimeout = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhId      = 3'd1,
    PhLen     = 3'd2,
    PhErr     = 3'd3,
    PhData    = 3'd4,
    PhSum     = 3'd5,
    PhDrainRd = 3'd6,
    PhDrainWr = 3'd7
  } phase_e;

  // Write and read requests toward the payload store.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  // One result to be loaded into the output register. The data byte itself
  // comes straight from the store's read register.
  typedef struct packed {
    logic             load;
    status_e          status;
    logic [7:0]       servo_id;
    logic [7:0]       error_byte;
    logic [7:0]       data_count;
    logic             has_data;
    logic [AddrW-1:0] byte_index;
    logic             last;
  } res_t;

endpackage

@@ rtl/core/sspr_payload_ram.sv @@
module sspr_payload_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned Depth = 1 << AddrW;

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sspr_ctrl.sv @@
module sspr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               timed_out_i,
  input  logic               out_free_i,
  output sspr_pkg::ram_req_t ram_o,
  output sspr_pkg::res_t     res_o
);

  import sspr_pkg::*;

  phase_e           phase_q, phase_d;
  logic [7:0]       prev_q, prev_d;
  logic [4:0]       hunt_q, hunt_d;
  logic [7:0]       id_q, id_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       err_q, err_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       rcvd_q, rcvd_d;
  logic [AddrW-1:0] idx_q, idx_d;

  logic       parsing;
  logic       accept;
  logic [7:0] count;
  logic [7:0] rcvd_inc;
  logic [4:0] hunt_inc;
  logic       idx_last;

  assign count    = len_q - MinLength;
  assign rcvd_inc = rcvd_q + 8'd1;
  assign hunt_inc = hunt_q + 5'd1;
  assign idx_last = ({{(8 - AddrW){1'b0}}, idx_q} == (count - 8'd1));

  assign parsing    = (phase_q != PhDrainRd) && (phase_q != PhDrainWr);
  assign in_ready_o = parsing && out_free_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      prev_q  <= '0;
      hunt_q  <= '0;
      id_q    <= '0;
      len_q   <= '0;
      err_q   <= '0;
      sum_q   <= '0;
      rcvd_q  <= '0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      hunt_q  <= hunt_d;
      id_q    <= id_d;
      len_q   <= len_d;
      err_q   <= err_d;
      sum_q   <= sum_d;
      rcvd_q  <= rcvd_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    logic fail;
    logic restart;
    status_e fail_code;

    phase_d   = phase_q;
    prev_d    = prev_q;
    hunt_d    = hunt_q;
    id_d      = id_q;
    len_d     = len_q;
    err_d     = err_q;
    sum_d     = sum_q;
    rcvd_d    = rcvd_q;
    idx_d     = idx_q;
    fail      = 1'b0;
    restart   = 1'b0;
    fail_code = StOk;

    ram_o       = '0;
    ram_o.waddr = rcvd_q[AddrW-1:0];
    ram_o.wdata = rx_byte_i;
    ram_o.raddr = idx_q;
    res_o       = '0;

    if (accept && timed_out_i) begin
      fail      = 1'b1;
      fail_code = StTimeout;
    end else begin
      case (phase_q)
        PhHunt: begin
          if (accept) begin
            if (prev_q == HeaderByte && rx_byte_i == HeaderByte) begin
              phase_d = PhId;
            end else begin
              prev_d = rx_byte_i;
              hunt_d = hunt_inc;
              if (hunt_inc >= HuntLimit) begin
                fail      = 1'b1;
                fail_code = StNoHdr;
              end
            end
          end
        end
        PhId: begin
          if (accept) begin
            id_d    = rx_byte_i;
            phase_d = PhLen;
          end
        end
        PhLen: begin
          if (accept) begin
            len_d   = rx_byte_i;
            phase_d = PhErr;
          end
        end
        PhErr: begin
          if (accept) begin
            err_d = rx_byte_i;
            if (len_q < MinLength) begin
              fail      = 1'b1;
              fail_code = StShort;
            end else begin
              sum_d   = id_q + len_q + rx_byte_i;
              rcvd_d  = '0;
              phase_d = (len_q == MinLength) ? PhSum : PhData;
            end
          end
        end
        PhData: begin
          if (accept) begin
            // Bytes past the store depth still count toward length and sum.
            ram_o.we = (rcvd_q < 8'(MaxData));
            sum_d    = sum_q + rx_byte_i;
            rcvd_d   = rcvd_inc;
            if (rcvd_inc >= count) begin
              phase_d = PhSum;
            end
          end
        end
        PhSum: begin
          if (accept) begin
            if (~sum_q != rx_byte_i) begin
              fail      = 1'b1;
              fail_code = StCsum;
            end else if (count > 8'(MaxData)) begin
              fail      = 1'b1;
              fail_code = StLong;
            end else if (count == 8'd0) begin
              res_o.load       = 1'b1;
              res_o.status     = StOk;
              res_o.servo_id   = id_q;
              res_o.error_byte = err_q;
              res_o.last       = 1'b1;
              restart          = 1'b1;
            end else begin
              idx_d   = '0;
              phase_d = PhDrainRd;
            end
          end
        end
        PhDrainRd: begin
          ram_o.re = 1'b1;
          phase_d  = PhDrainWr;
        end
        PhDrainWr: begin
          if (out_free_i) begin
            res_o.load       = 1'b1;
            res_o.status     = StOk;
            res_o.servo_id   = id_q;
            res_o.error_byte = err_q;
            res_o.data_count = count;
            res_o.has_data   = 1'b1;
            res_o.byte_index = idx_q;
            res_o.last       = idx_last;
            if (idx_last) begin
              restart = 1'b1;
            end else begin
              idx_d   = idx_q + 1'b1;
              phase_d = PhDrainRd;
            end
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
    end

    if (fail) begin
      res_o.load   = 1'b1;
      res_o.status = fail_code;
      res_o.last   = 1'b1;
      restart      = 1'b1;
    end

    if (restart) begin
      phase_d = PhHunt;
      prev_d  = '0;
      hunt_d  = '0;
    end
  end

  // The store is never written and read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_o.we && ram_o.re))
    else $error("payload store written and read together");

  // A result is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.load |-> out_free_i)
    else $error("result loaded into a full output register");

  // The final result of a run always returns the parser to the hunt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.load && res_o.last |=> phase_q == PhHunt)
    else $error("run ended without returning to the hunt");

  // A drain read is followed by the load cycle for that entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_o.re |=> phase_q == PhDrainWr && $stable(idx_q))
    else $error("drain read not followed by its load cycle");

endmodule

@@ rtl/core/servo_status_packet_receiver.sv @@
// Status packet receiver for a half-duplex servo bus. Each input item is a
// received byte or a timeout event. While a packet is being parsed one item
// is taken per cycle, except in cycles where a result waits in the output
// register and is not taken on that edge. A finished packet produces a run
// of results: a failure or an empty good packet gives one result, loaded in
// the cycle its last byte is taken; a good packet with n data bytes drains
// from the payload store as n results, each a store read (PhDrainRd) then a
// load of the output register (PhDrainWr), and no input is taken during
// that drain.
// The store needs no clearing pass after reset: only entries written by the
// current packet are ever read back.
module servo_status_packet_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       timed_out_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [7:0] servo_id_o,
  output logic [7:0] error_byte_o,
  output logic [7:0] data_count_o,
  output logic       has_data_o,
  output logic [5:0] byte_index_o,
  output logic [7:0] data_byte_o,
  output logic       last_o
);

  import sspr_pkg::*;

  ram_req_t   ram_req;
  res_t       res;
  logic [7:0] rdata;
  logic       out_free;

  logic       out_valid_q, out_valid_d;
  res_t       res_q;
  logic [7:0] data_q;

  assign out_free = !out_valid_q || out_ready_i;

  sspr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .timed_out_i (timed_out_i),
    .out_free_i  (out_free),
    .ram_o       (ram_req),
    .res_o       (res)
  );

  sspr_payload_ram #(
    .Width (8),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      res_q  <= res;
      data_q <= res.has_data ? rdata : 8'd0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign servo_id_o   = res_q.servo_id;
  assign error_byte_o = res_q.error_byte;
  assign data_count_o = res_q.data_count;
  assign has_data_o   = res_q.has_data;
  assign byte_index_o = res_q.byte_index;
  assign data_byte_o  = data_q;
  assign last_o       = res_q.last;

endmodule
